@@ rtl/core/rsi_pkg.sv @@
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared constants for the ray / sphere intersection pipeline.
// ----------------------------------------------------------------------------
package rsi_pkg;

  // Fraction bits of the unit direction components
  localparam int UNIT_BITS = 30;

  // Radius register
  localparam int RADIUS_W = 20;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 20'd65536;

  // Distance result
  localparam int DIST_W = 31;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

endpackage

@@ rtl/core/rsi_sqrt_pipe.sv @@
// ----------------------------------------------------------------------------
// rsi_sqrt_pipe
// Pipelined integer square root, one result bit per stage, with a sideband
// payload that travels alongside the radicand.
// ----------------------------------------------------------------------------
module rsi_sqrt_pipe #(
  parameter int RW = 31,
  parameter int PW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [2*RW-1:0] radicand,
  input  logic [PW-1:0]   in_pay,
  output logic            out_valid,
  output logic [RW-1:0]   root,
  output logic [PW-1:0]   out_pay
);

  logic              v_q    [1:RW];
  logic [RW-1:0]     root_q [1:RW];
  logic [PW-1:0]     pay_q  [1:RW];
  logic [RW+1:0]     rem_q  [1:RW-1];
  logic [2*RW-1:0]   rad_q  [1:RW-1];

  for (genvar k = 0; k < RW; k++) begin : g_step
    logic            v_in;
    logic [RW+1:0]   rem_in;
    logic [RW-1:0]   root_in;
    logic [2*RW-1:0] rad_in;
    logic [PW-1:0]   pay_in;
    logic [RW+1:0]   rem_sh;
    logic [RW+1:0]   trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = radicand;
      assign pay_in  = in_pay;
    end else begin : g_rest
      assign v_in    = v_q[k];
      assign rem_in  = rem_q[k];
      assign root_in = root_q[k];
      assign rad_in  = rad_q[k];
      assign pay_in  = pay_q[k];
    end

    // bring down two radicand bits and try the next root bit
    assign rem_sh = {rem_in[RW-1:0], rad_in[2*RW-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k+1] <= 1'b0;
      end else if (en) begin
        v_q[k+1] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root_q[k+1] <= {root_in[RW-2:0], ge};
        pay_q[k+1]  <= pay_in;
      end
    end

    // the last stage needs no remainder
    if (k < RW-1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[k+1] <= ge ? (rem_sh - trial) : rem_sh;
          rad_q[k+1] <= rad_in << 2;
        end
      end
    end
  end

  assign out_valid = v_q[RW];
  assign root      = root_q[RW];
  assign out_pay   = pay_q[RW];

endmodule

@@ rtl/core/rsi_div_pipe.sv @@
// ----------------------------------------------------------------------------
// rsi_div_pipe
// Pipelined restoring divider, one quotient bit per stage, three lanes that
// share one divisor. The quotient must fit in QW bits.
// ----------------------------------------------------------------------------
module rsi_div_pipe #(
  parameter int NW    = 60,
  parameter int DW    = 31,
  parameter int QW    = 31,
  parameter int LANES = 3,
  parameter int PW    = 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [LANES-1:0][NW-1:0]  num,
  input  logic [DW-1:0]             den,
  input  logic [PW-1:0]             in_pay,
  output logic                      out_valid,
  output logic [LANES-1:0][QW-1:0]  quo,
  output logic [PW-1:0]             out_pay
);

  logic                      v_q   [1:QW];
  logic [LANES-1:0][QW-1:0]  q_q   [1:QW];
  logic [PW-1:0]             pay_q [1:QW];
  logic [LANES-1:0][DW-1:0]  rem_q [1:QW-1];
  logic [LANES-1:0][QW-1:0]  low_q [1:QW-1];
  logic [DW-1:0]             den_q [1:QW-1];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic                      v_in;
    logic [LANES-1:0][DW-1:0]  rem_in;
    logic [LANES-1:0][QW-1:0]  low_in;
    logic [LANES-1:0][QW-1:0]  q_in;
    logic [DW-1:0]             den_in;
    logic [PW-1:0]             pay_in;
    logic [LANES-1:0][DW:0]    rem_sh;
    logic [LANES-1:0]          ge;
    logic [LANES-1:0][DW-1:0]  rem_nx;
    logic [LANES-1:0][QW-1:0]  q_nx;
    logic [LANES-1:0][QW-1:0]  low_nx;

    if (k == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          rem_in[l] = DW'(num[l][NW-1:QW]);
          low_in[l] = num[l][QW-1:0];
        end
      end
      assign v_in   = in_valid;
      assign q_in   = '0;
      assign den_in = den;
      assign pay_in = in_pay;
    end else begin : g_rest
      assign v_in   = v_q[k];
      assign rem_in = rem_q[k];
      assign low_in = low_q[k];
      assign q_in   = q_q[k];
      assign den_in = den_q[k];
      assign pay_in = pay_q[k];
    end

    // shift in the next dividend bit and subtract when it fits
    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        rem_sh[l] = {rem_in[l], low_in[l][QW-1]};
        ge[l]     = (rem_sh[l] >= {1'b0, den_in});
        rem_nx[l] = ge[l] ? DW'(rem_sh[l] - {1'b0, den_in}) : DW'(rem_sh[l]);
        q_nx[l]   = {q_in[l][QW-2:0], ge[l]};
        low_nx[l] = low_in[l] << 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k+1] <= 1'b0;
      end else if (en) begin
        v_q[k+1] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_q[k+1]   <= q_nx;
        pay_q[k+1] <= pay_in;
      end
    end

    if (k < QW-1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[k+1] <= rem_nx;
          low_q[k+1] <= low_nx;
          den_q[k+1] <= den_in;
        end
      end
    end
  end

  assign out_valid = v_q[QW];
  assign quo       = q_q[QW];
  assign out_pay   = pay_q[QW];

endmodule

@@ rtl/core/ray_sphere_intersect.sv @@
// ----------------------------------------------------------------------------
// ray_sphere_intersect
// Ray / sphere hit test in signed fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: in_valid / in_stall carry origin, direction and center.
//   Result channel: out_valid / out_stall carry hit and distance.
//   Config channel: cfg_valid / cfg_ready / cfg_data write the sphere radius;
//   cfg_ready is always high. Write it only while the pipeline is empty.
// Throughput: one request per cycle while in_stall is low.
// Pipeline: registered stages A to E, the bit-per-stage length square root, stage F,
//   the bit-per-stage divider, stages G to K, the bit-per-stage disc square root and L.
// Stalls: the whole pipeline advances together; while a result is held by
//   out_stall the pipeline freezes and in_stall is raised, nothing is lost.
// Reset: rst clears all valid bits and sets the radius to 1.0.
// ----------------------------------------------------------------------------
module ray_sphere_intersect
  import rsi_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] origin_x,
  input  logic signed [COORD_WIDTH-1:0] origin_y,
  input  logic signed [COORD_WIDTH-1:0] origin_z,
  input  logic signed [COORD_WIDTH-1:0] dir_x,
  input  logic signed [COORD_WIDTH-1:0] dir_y,
  input  logic signed [COORD_WIDTH-1:0] dir_z,
  input  logic signed [COORD_WIDTH-1:0] center_x,
  input  logic signed [COORD_WIDTH-1:0] center_y,
  input  logic signed [COORD_WIDTH-1:0] center_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          hit,
  output logic [DIST_W-1:0]             distance,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [RADIUS_W-1:0]           cfg_data
);

  localparam int CW  = COORD_WIDTH;
  localparam int UB  = UNIT_BITS;
  localparam int LW  = UB + 1;
  localparam int QW  = UB + 1;
  localparam int NW  = 2 * UB;
  localparam int M2W = 2 * CW + 2;
  localparam int BLW = $clog2(CW + UB + 1);
  localparam int PRW = CW + QW;
  localparam int BW  = PRW + 3;
  localparam int BFW = BW - UB;
  localparam int SRW = BFW + 1;
  localparam int DSW = 2 * SRW + 1;
  localparam int R2W = 2 * RADIUS_W;
  localparam int CMW = (M2W > R2W) ? M2W : R2W;
  localparam int TW  = (SRW > DIST_W) ? SRW : DIST_W + 1;
  localparam int SSW = 2 * FRAC_BITS + 2;
  localparam logic [SSW-1:0] SHORT_MAX =
    SSW'((64'd1 << (2 * FRAC_BITS)) / 64'd1000000);

  typedef struct packed {
    logic [2:0][UB-1:0] ds;
    logic [2:0]         dneg;
    logic [2:0][CW-1:0] mmag;
    logic [2:0]         mneg;
    logic [M2W-1:0]     mm2;
    logic               short_dir;
  } len_pay_t;

  typedef struct packed {
    logic [2:0]         tneg;
    logic [2:0][CW-1:0] mmag;
    logic [M2W-1:0]     mm2;
    logic               short_dir;
  } div_pay_t;

  typedef struct packed {
    logic [BFW-1:0] bfm;
    logic           bneg;
    logic           miss;
  } root_pay_t;

  logic en;
  logic [RADIUS_W-1:0] sphere_radius;

  // advance every stage unless a finished result is held
  assign en        = !out_valid || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sphere_radius <= RADIUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      sphere_radius <= cfg_data;
    end
  end

  // ---------------- stage A: magnitudes and signs
  logic [2:0][CW-1:0] o_in, d_in, c_in;
  logic [2:0][CW:0]   m_diff, m_abs;
  logic [2:0][CW-1:0] a_dmag_next;
  logic               a_valid;
  logic [2:0][CW-1:0] a_dmag, a_mmag;
  logic [2:0]         a_dneg, a_mneg;

  assign o_in = {origin_z, origin_y, origin_x};
  assign d_in = {dir_z, dir_y, dir_x};
  assign c_in = {center_z, center_y, center_x};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_dmag_next[i] = d_in[i][CW-1] ? (~d_in[i] + 1'b1) : d_in[i];
      m_diff[i] = {o_in[i][CW-1], o_in[i]} - {c_in[i][CW-1], c_in[i]};
      m_abs[i]  = m_diff[i][CW] ? (~m_diff[i] + 1'b1) : m_diff[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_dmag[i] <= a_dmag_next[i];
        a_dneg[i] <= d_in[i][CW-1];
        a_mmag[i] <= m_abs[i][CW-1:0];
        a_mneg[i] <= m_diff[i][CW];
      end
    end
  end

  // ---------------- stage B: short test, leading bit, squares of m
  logic [CW-1:0]       or_mag;
  logic [BLW-1:0]      bl_next;
  logic                all_low;
  logic [SSW-1:0]      short_sum;
  logic                b_valid, b_short;
  logic [BLW-1:0]      b_bl;
  logic [2:0][CW-1:0]  b_dmag, b_mmag;
  logic [2:0]          b_dneg, b_mneg;
  logic [2:0][2*CW-1:0] b_msq;

  assign or_mag = a_dmag[0] | a_dmag[1] | a_dmag[2];

  always_comb begin
    bl_next = '0;
    for (int i = 0; i < CW; i++) begin
      if (or_mag[i]) bl_next = BLW'(i + 1);
    end
    all_low   = 1'b1;
    short_sum = '0;
    for (int i = 0; i < 3; i++) begin
      if (a_dmag[i][CW-1:FRAC_BITS] != '0) all_low = 1'b0;
      short_sum = short_sum + SSW'(a_dmag[i][FRAC_BITS-1:0])
                            * SSW'(a_dmag[i][FRAC_BITS-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_short <= all_low && (short_sum <= SHORT_MAX);
      b_bl    <= bl_next;
      b_dmag  <= a_dmag;
      b_dneg  <= a_dneg;
      b_mmag  <= a_mmag;
      b_mneg  <= a_mneg;
      for (int i = 0; i < 3; i++) begin
        b_msq[i] <= (2*CW)'(a_mmag[i]) * (2*CW)'(a_mmag[i]);
      end
    end
  end

  // ---------------- stage C: scale direction, sum |m|^2
  logic [2:0][CW+UB-1:0] d_ext, d_sh;
  logic                  c_valid, c_short;
  logic [2:0][UB-1:0]    c_ds;
  logic [2:0]            c_dneg, c_mneg;
  logic [2:0][CW-1:0]    c_mmag;
  logic [M2W-1:0]        c_mm2;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_ext[i] = (CW+UB)'(b_dmag[i]);
      if (b_bl > BLW'(UB)) d_sh[i] = d_ext[i] >> (b_bl - BLW'(UB));
      else d_sh[i] = d_ext[i] << (BLW'(UB) - b_bl);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) c_ds[i] <= d_sh[i][UB-1:0];
      c_mm2   <= M2W'(b_msq[0]) + M2W'(b_msq[1]) + M2W'(b_msq[2]);
      c_short <= b_short;
      c_dneg  <= b_dneg;
      c_mmag  <= b_mmag;
      c_mneg  <= b_mneg;
    end
  end

  // ---------------- stage D: squares of scaled direction
  logic                  d_valid;
  logic [2:0][2*UB-1:0]  d_dsq;
  len_pay_t              d_pay;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d_dsq[i] <= (2*UB)'(c_ds[i]) * (2*UB)'(c_ds[i]);
      end
      d_pay.ds        <= c_ds;
      d_pay.dneg      <= c_dneg;
      d_pay.mmag      <= c_mmag;
      d_pay.mneg      <= c_mneg;
      d_pay.mm2       <= c_mm2;
      d_pay.short_dir <= c_short;
    end
  end

  // ---------------- stage E: squared length
  logic            e_valid;
  logic [2*LW-1:0] e_l2;
  len_pay_t        e_pay;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (en) begin
      e_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_l2  <= (2*LW)'(d_dsq[0]) + (2*LW)'(d_dsq[1]) + (2*LW)'(d_dsq[2]);
      e_pay <= d_pay;
    end
  end

  // ---------------- length = floor(sqrt(l2))
  logic          len_valid;
  logic [LW-1:0] len;
  len_pay_t      len_pay;

  rsi_sqrt_pipe #(
    .RW (LW),
    .PW ($bits(len_pay_t))
  ) u_len_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (e_valid),
    .radicand  (e_l2),
    .in_pay    (e_pay),
    .out_valid (len_valid),
    .root      (len),
    .out_pay   (len_pay)
  );

  // ---------------- stage F: rounded dividends for the unit vector
  logic               f_valid;
  logic [2:0][NW-1:0] f_num;
  logic [LW-1:0]      f_den;
  div_pay_t           f_pay;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (en) begin
      f_valid <= len_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        f_num[i] <= {len_pay.ds[i], {UB{1'b0}}} + NW'(len >> 1);
      end
      f_den           <= len;
      f_pay.tneg      <= len_pay.mneg ^ len_pay.dneg;
      f_pay.mmag      <= len_pay.mmag;
      f_pay.mm2       <= len_pay.mm2;
      f_pay.short_dir <= len_pay.short_dir;
    end
  end

  // ---------------- unit vector u = d * 2^UB / len
  logic               u_valid;
  logic [2:0][QW-1:0] u_vec;
  div_pay_t           u_pay;

  rsi_div_pipe #(
    .NW    (NW),
    .DW    (LW),
    .QW    (QW),
    .LANES (3),
    .PW    ($bits(div_pay_t))
  ) u_unit_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .num       (f_num),
    .den       (f_den),
    .in_pay    (f_pay),
    .out_valid (u_valid),
    .quo       (u_vec),
    .out_pay   (u_pay)
  );

  // ---------------- stage G: products m * u and r^2
  logic                g_valid, g_short;
  logic [2:0][PRW-1:0] g_prod;
  logic [2:0]          g_tneg;
  logic [M2W-1:0]      g_mm2;
  logic [R2W-1:0]      g_r2;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else if (en) begin
      g_valid <= u_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        g_prod[i] <= PRW'(u_pay.mmag[i]) * PRW'(u_vec[i]);
      end
      g_r2    <= R2W'(sphere_radius) * R2W'(sphere_radius);
      g_tneg  <= u_pay.tneg;
      g_mm2   <= u_pay.mm2;
      g_short <= u_pay.short_dir;
    end
  end

  // ---------------- stage H: b = m . u, exact
  logic signed [BW-1:0] term [3];
  logic                 h_valid, h_short;
  logic signed [BW-1:0] h_b;
  logic [M2W-1:0]       h_mm2;
  logic [R2W-1:0]       h_r2;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      term[i] = signed'(BW'(g_prod[i]));
      if (g_tneg[i]) term[i] = -term[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid <= 1'b0;
    end else if (en) begin
      h_valid <= g_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_b     <= term[0] + term[1] + term[2];
      h_mm2   <= g_mm2;
      h_r2    <= g_r2;
      h_short <= g_short;
    end
  end

  // ---------------- stage I: round b, short-direction and outside-and-away reject
  logic           b_is_neg, b_is_pos, c_is_pos;
  logic [BW-1:0]  b_abs, b_rnd;
  logic           i_valid, i_bneg, i_miss;
  logic [BFW-1:0] i_bfm;
  logic [M2W-1:0] i_mm2;
  logic [R2W-1:0] i_r2;

  always_comb begin
    b_is_neg = h_b[BW-1];
    b_is_pos = !b_is_neg && (h_b != '0);
    b_abs    = b_is_neg ? BW'(-h_b) : BW'(h_b);
    b_rnd    = b_abs + (BW'(1) << (UB - 1));
    c_is_pos = CMW'(h_mm2) > CMW'(h_r2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      i_valid <= 1'b0;
    end else if (en) begin
      i_valid <= h_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      i_bfm  <= b_rnd[BW-1:UB];
      i_bneg <= b_is_neg;
      i_miss <= h_short || (c_is_pos && b_is_pos);
      i_mm2  <= h_mm2;
      i_r2   <= h_r2;
    end
  end

  // ---------------- stage J: b^2
  logic             j_valid;
  logic [2*BFW-1:0] j_bf2;
  logic [M2W-1:0]   j_mm2;
  logic [R2W-1:0]   j_r2;
  root_pay_t        j_pay;

  always_ff @(posedge clk) begin
    if (rst) begin
      j_valid <= 1'b0;
    end else if (en) begin
      j_valid <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      j_bf2      <= (2*BFW)'(i_bfm) * (2*BFW)'(i_bfm);
      j_mm2      <= i_mm2;
      j_r2       <= i_r2;
      j_pay.bfm  <= i_bfm;
      j_pay.bneg <= i_bneg;
      j_pay.miss <= i_miss;
    end
  end

  // ---------------- stage K: discriminant, negative means miss
  logic [DSW-1:0]   disc;
  logic             k_valid;
  logic [2*SRW-1:0] k_rad;
  root_pay_t        k_pay;

  assign disc = DSW'(j_bf2) + DSW'(j_r2) - DSW'(j_mm2);

  always_ff @(posedge clk) begin
    if (rst) begin
      k_valid <= 1'b0;
    end else if (en) begin
      k_valid <= j_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k_rad      <= disc[2*SRW-1:0];
      k_pay.bfm  <= j_pay.bfm;
      k_pay.bneg <= j_pay.bneg;
      k_pay.miss <= j_pay.miss || disc[DSW-1];
    end
  end

  // ---------------- s = floor(sqrt(disc))
  logic           s_valid;
  logic [SRW-1:0] s_root;
  root_pay_t      s_pay;

  rsi_sqrt_pipe #(
    .RW (SRW),
    .PW ($bits(root_pay_t))
  ) u_disc_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (k_valid),
    .radicand  (k_rad),
    .in_pay    (k_pay),
    .out_valid (s_valid),
    .root      (s_root),
    .out_pay   (s_pay)
  );

  // ---------------- stage L: near distance, clamp and saturate
  logic [SRW-1:0] t_raw;
  logic [TW-1:0]  t_ext;
  logic [DIST_W-1:0] t_sat;

  always_comb begin
    t_raw = '0;
    if (s_pay.bneg && (SRW'(s_pay.bfm) > s_root)) t_raw = SRW'(s_pay.bfm) - s_root;
    t_ext = TW'(t_raw);
    t_sat = (t_ext > TW'(DIST_MAX)) ? DIST_MAX : t_ext[DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit      <= !s_pay.miss;
      distance <= s_pay.miss ? '0 : t_sat;
    end
  end

endmodule

@@ rtl/core/rsi_checker.sv @@
// ----------------------------------------------------------------------------
// rsi_checker
// Port-level checks for ray_sphere_intersect, bound to the top level.
// ----------------------------------------------------------------------------
module rsi_checker
  import rsi_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic              hit,
  input logic [DIST_W-1:0] distance
);

  // hold a stalled result
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(hit) && $stable(distance))
    else $error("stalled result changed");

  // a miss reports zero distance
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> distance == '0)
    else $error("miss with nonzero distance");

  // the request side stalls exactly when a result is held
  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("request stall not tied to held result");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind ray_sphere_intersect rsi_checker u_rsi_checker (.*);

@@ sim/ray_sphere_intersect_tb.sv @@
// ----------------------------------------------------------------------------
// ray_sphere_intersect_tb
// Self-checking bench for the ray / sphere hit test. Requests are driven with
// random gaps and result stalls, each result is checked against a bit-exact
// predictor, and the radius register is swept across its range between phases.
// ----------------------------------------------------------------------------
module ray_sphere_intersect_tb;
  import rsi_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW          = 32;
  localparam int FB          = 16;
  localparam int DRAIN_WAIT  = 120;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [2:0][CW-1:0] org;
    logic [2:0][CW-1:0] dir;
    logic [2:0][CW-1:0] ctr;
  } ray_t;

  typedef struct packed {
    logic              hit;
    logic [DIST_W-1:0] dist_val;
  } hit_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic signed [CW-1:0] origin_x, origin_y, origin_z;
  logic signed [CW-1:0] dir_x, dir_y, dir_z;
  logic signed [CW-1:0] center_x, center_y, center_z;
  logic                out_valid;
  logic                out_stall;
  logic                hit;
  logic [DIST_W-1:0]   distance;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [RADIUS_W-1:0] cfg_data;

  hit_t                expected_hits[$];
  logic [RADIUS_W-1:0] radius;
  int                  send_idle_pct;
  int                  recv_idle_pct;
  int                  mismatches;
  int                  cycles;

  ray_sphere_intersect #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .origin_x  (origin_x),
    .origin_y  (origin_y),
    .origin_z  (origin_z),
    .dir_x     (dir_x),
    .dir_y     (dir_y),
    .dir_z     (dir_z),
    .center_x  (center_x),
    .center_y  (center_y),
    .center_z  (center_z),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .hit       (hit),
    .distance  (distance),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Integer square root, floor
  function automatic logic [63:0] isqrt(logic [127:0] n);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      c = r | (64'd1 << i);
      if (128'(c) * 128'(c) <= n) r = c;
    end
    return r;
  endfunction

  // Predict hit and distance for one request at the given radius
  function automatic hit_t trace_sphere(ray_t r, logic [RADIUS_W-1:0] rad);
    logic [63:0]         dm[3];
    logic [63:0]         mm[3];
    logic [63:0]         u[3];
    logic                dn[3];
    logic                mn[3];
    longint              sd;
    logic [63:0]         mx, l2, len, sum, bfm, s, t;
    logic                short_dir, cpos, bneg;
    int                  bl;
    logic signed [127:0] bacc;
    logic [127:0]        babs, prod, mm2, r2, bf2, cm, disc;
    hit_t                res;
    res = '0;
    mx = 0;
    short_dir = 1'b1;
    for (int i = 0; i < 3; i++) begin
      sd = longint'($signed(r.dir[i]));
      dn[i] = sd < 0;
      dm[i] = dn[i] ? -sd : sd;
      sd = longint'($signed(r.org[i])) - longint'($signed(r.ctr[i]));
      mn[i] = sd < 0;
      mm[i] = mn[i] ? -sd : sd;
      if (dm[i] >= (64'd1 << FB)) short_dir = 1'b0;
      if (dm[i] > mx) mx = dm[i];
    end
    // reject a direction too short to normalize
    if (short_dir) begin
      sum = dm[0] * dm[0] + dm[1] * dm[1] + dm[2] * dm[2];
      if (sum <= (64'd1 << (2 * FB)) / 64'd1000000) return res;
    end
    if (mx == 0) return res;
    // normalize to Q.30
    bl = 0;
    while (bl < 64 && (mx >> bl) != 0) bl++;
    l2 = 0;
    for (int i = 0; i < 3; i++) begin
      if (bl > UNIT_BITS) dm[i] = dm[i] >> (bl - UNIT_BITS);
      else dm[i] = dm[i] << (UNIT_BITS - bl);
      l2 += dm[i] * dm[i];
    end
    len = isqrt(128'(l2));
    if (len == 0) return res;
    for (int i = 0; i < 3; i++)
      u[i] = ((dm[i] << UNIT_BITS) + len / 2) / len;
    // b = m.u and |m|^2
    bacc = '0;
    mm2 = '0;
    for (int i = 0; i < 3; i++) begin
      prod = 128'(mm[i]) * 128'(u[i]);
      if (mn[i] != dn[i]) bacc = bacc - $signed(prod);
      else bacc = bacc + $signed(prod);
      mm2 += 128'(mm[i]) * 128'(mm[i]);
    end
    r2 = 128'(rad) * 128'(rad);
    cpos = mm2 > r2;
    bneg = bacc < 0;
    if (cpos && bacc > 0) return res;
    babs = bneg ? -bacc : bacc;
    bfm = 64'((babs + (128'd1 << (UNIT_BITS - 1))) >> UNIT_BITS);
    bf2 = 128'(bfm) * 128'(bfm);
    if (cpos) begin
      cm = mm2 - r2;
      if (bf2 < cm) return res;
      disc = bf2 - cm;
    end else begin
      disc = bf2 + (r2 - mm2);
    end
    s = isqrt(disc);
    t = (bneg && bfm > s) ? bfm - s : 64'd0;
    if (t > 64'(DIST_MAX)) t = 64'(DIST_MAX);
    res.hit = 1'b1;
    res.dist_val = t[DIST_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  // Send one request, holding it until accepted
  task automatic send_ray(ray_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {origin_x, origin_y, origin_z} <= {r.org[0], r.org[1], r.org[2]};
    {dir_x, dir_y, dir_z}          <= {r.dir[0], r.dir[1], r.dir[2]};
    {center_x, center_y, center_z} <= {r.ctr[0], r.ctr[1], r.ctr[2]};
    do @(posedge clk); while (in_stall);
    expected_hits.push_back(trace_sphere(r, radius));
  endtask

  // Hold off until every pending result is back, then let the pipe empty
  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_radius(logic [RADIUS_W-1:0] value);
    drain_pipe();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    radius = value;
  endtask

  function automatic ray_t make_ray(int ox, int oy, int oz, int dx, int dy, int dz,
                                    int cx, int cy, int cz);
    ray_t r;
    r.org = {32'(oz), 32'(oy), 32'(ox)};
    r.dir = {32'(dz), 32'(dy), 32'(dx)};
    r.ctr = {32'(cz), 32'(cy), 32'(cx)};
    return r;
  endfunction

  // Ray aimed near a sphere center, with random scale and jitter
  function automatic ray_t aimed_ray();
    ray_t r;
    int   off, span, jit, k;
    span = (radius == 0) ? 65536 : 8 * int'(radius);
    k = $urandom_range(3);
    jit = $urandom_range(2) == 0 ? 0 : span / 4;
    for (int i = 0; i < 3; i++) begin
      r.ctr[i] = $signed($urandom_range(2097152)) - 1048576;
      off = $urandom_range(1) ? $signed($urandom_range(span)) : -$signed($urandom_range(span));
      r.org[i] = $signed(r.ctr[i]) + off;
      // mostly point toward the center, sometimes away
      r.dir[i] = (($urandom_range(4) == 0) ? off : -off) + $signed($urandom_range(2 * jit)) - jit;
      r.dir[i] = $signed(r.dir[i]) >>> k;
    end
    return r;
  endfunction

  // Extremes, short directions, inside origin, away-pointing, saturation
  task automatic test_directed();
    int big;
    int low;
    big = 32'h7fffffff;
    low = 32'h80000000;
    send_ray(make_ray(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_ray(make_ray(-5 << 16, 0, 0, 65, 0, 0, 0, 0, 0));
    send_ray(make_ray(-5 << 16, 0, 0, 66, 0, 0, 0, 0, 0));
    send_ray(make_ray(-5 << 16, 0, 0, 37, 37, 37, 0, 0, 0));
    send_ray(make_ray(-5 << 16, 0, 0, 65535, 1, 0, 0, 0, 0));
    send_ray(make_ray(-5 << 16, 0, 0, 1 << 16, 0, 0, 0, 0, 0));
    send_ray(make_ray(5 << 16, 0, 0, 1 << 16, 0, 0, 0, 0, 0));
    send_ray(make_ray(0, 0, 0, 3, -7, 11, 1 << 14, 0, 0));
    send_ray(make_ray(0, 5 << 16, 0, 1 << 16, 0, 0, 0, 0, 0));
    send_ray(make_ray(-3 << 16, 1 << 16, 0, 1 << 16, 0, 0, 0, 0, 0));
    send_ray(make_ray(low, 0, 0, big, 0, 0, big, 0, 0));
    send_ray(make_ray(low, low, low, big, big, big, big, big, big));
    send_ray(make_ray(big, big, big, low, low, low, low, low, low));
    send_ray(make_ray(big, low, big, low, big, low, low, big, low));
    send_ray(make_ray(low, big, low, big, big, big, low, big, low));
    send_ray(make_ray(-1, -1, -1, -1, -1, -1, 0, 0, 0));
    send_ray(make_ray(0, -10 << 16, 0, 0, low, 0, 0, 0, 0));
    send_ray(make_ray(0, -10 << 16, 0, 0, big, 0, 0, 0, 0));
  endtask

  // Mostly aimed rays, mixed with small random and fully random noise
  task automatic test_random(int count);
    ray_t r;
    int   pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        r = aimed_ray();
      end else if (pick < 80) begin
        for (int i = 0; i < 3; i++) begin
          r.org[i] = $signed($urandom_range(1 << 22)) - (1 << 21);
          r.dir[i] = $signed($urandom_range(1 << 12)) - (1 << 11);
          r.ctr[i] = $signed($urandom_range(1 << 22)) - (1 << 21);
        end
      end else begin
        r.org = {$urandom, $urandom, $urandom};
        r.dir = {$urandom, $urandom, $urandom};
        r.ctr = {$urandom, $urandom, $urandom};
      end
      send_ray(r);
    end
  endtask

  // Hold the result channel at random
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Check each accepted result against the oldest prediction
  always @(posedge clk) begin
    hit_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_hits.size() == 0) begin
        report_mismatch("unexpected result", {63'd0, hit}, 64'd0);
      end else begin
        want = expected_hits.pop_front();
        if (hit !== want.hit) report_mismatch("hit", {63'd0, hit}, {63'd0, want.hit});
        if (distance !== want.dist_val)
          report_mismatch("distance", 64'(distance), 64'(want.dist_val));
      end
    end
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    cycles        = 0;
    mismatches    = 0;
    radius        = RADIUS_RESET;
    send_idle_pct = 22;
    recv_idle_pct = 86;
    rst           = 1'b1;
    in_valid      = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    out_stall     = 1'b0;
    {origin_x, origin_y, origin_z} = '0;
    {dir_x, dir_y, dir_z}          = '0;
    {center_x, center_y, center_z} = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset radius then 6554, sender mostly active, receiver heavily stalled
    test_directed();
    test_random(150);
    write_radius(20'd6554);
    test_directed();
    test_random(150);

    // swap idling
    send_idle_pct = 86;
    recv_idle_pct = 22;
    write_radius(20'd655360);
    test_directed();
    test_random(150);
    write_radius('0);
    test_random(60);

    // full rate, both ways
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_radius({RADIUS_W{1'b1}});
    test_random(100);
    write_radius(RADIUS_W'($urandom_range(655360, 6554)));
    test_directed();
    test_random(200);
    write_radius(20'd65536);
    test_random(100);

    drain_pipe();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/rsi_pkg.sv
rtl/core/rsi_sqrt_pipe.sv
rtl/core/rsi_div_pipe.sv
rtl/core/ray_sphere_intersect.sv
rtl/core/rsi_checker.sv
sim/ray_sphere_intersect_tb.sv
